FILE: src/bfis_pkg.sv
// Shared types, opcodes and defaults for the Brainfuck instruction step engine.
package bfis_pkg;

    localparam int CELL_COUNT_DEF = 65536;
    localparam int CODE_DEPTH_DEF = 4096;

    localparam int BYTE_W   = 8;
    localparam int LEN_W    = 13;
    localparam int ADDR_W   = 12;
    localparam int CP_OUT_W = 13;
    localparam int DP_OUT_W = 16;

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_EXEC = 1'b1;

    localparam logic [BYTE_W-1:0] OP_LEFT  = 8'h3C;  // <
    localparam logic [BYTE_W-1:0] OP_RIGHT = 8'h3E;  // >
    localparam logic [BYTE_W-1:0] OP_PLUS  = 8'h2B;  // +
    localparam logic [BYTE_W-1:0] OP_MINUS = 8'h2D;  // -
    localparam logic [BYTE_W-1:0] OP_OPEN  = 8'h5B;  // [
    localparam logic [BYTE_W-1:0] OP_CLOSE = 8'h5D;  // ]
    localparam logic [BYTE_W-1:0] OP_DOT   = 8'h2E;  // .
    localparam logic [BYTE_W-1:0] OP_COMMA = 8'h2C;  // ,
    localparam logic [BYTE_W-1:0] OP_HASH  = 8'h23;  // #

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_FSTEP,
        S_FCHECK,
        S_BSTEP,
        S_BCHECK,
        S_ADVANCE,
        S_CELL
    } t_state;

    typedef struct packed {
        logic              we;
        logic [BYTE_W-1:0] wdata;
    } t_cell_req;

    function automatic int max_int(input int a, input int b);
        return (a > b) ? a : b;
    endfunction

endpackage

FILE: src/bfis_alu.sv
// Shared increment/decrement unit with compare against a limit and a zero test.
module bfis_alu #(
    parameter int W = 18
) (
    input  logic [W-1:0] i_a,
    input  logic         i_dec,
    input  logic [W-1:0] i_cmp,
    output logic [W-1:0] o_sum,
    output logic         o_ge,
    output logic         o_a_zero
);
    always_comb begin
        o_sum    = i_dec ? (i_a - W'(1)) : (i_a + W'(1));
        o_ge     = (o_sum >= i_cmp);
        o_a_zero = (i_a == '0);
    end
endmodule

FILE: src/bfis_cells.sv
// Data cell memory with a clearing sweep after reset.
module bfis_cells #(
    parameter int CELL_COUNT = 65536,
    parameter int DAW        = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  bfis_pkg::t_cell_req       i_req,
    input  logic [DAW-1:0]            i_addr,
    output logic [bfis_pkg::BYTE_W-1:0] o_q,
    output logic                      o_busy
);
    import bfis_pkg::*;

    logic [BYTE_W-1:0] cell_mem [CELL_COUNT];
    logic [DAW-1:0]    r_clr;
    logic              r_clearing;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr      <= '0;
            r_clearing <= 1'b1;
        end else if (r_clearing) begin
            r_clr <= r_clr + DAW'(1);
            if (r_clr == DAW'(CELL_COUNT - 1)) begin
                r_clearing <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clearing) begin
            cell_mem[r_clr] <= '0;
        end else if (i_req.we) begin
            cell_mem[i_addr] <= i_req.wdata;
        end
        o_q <= cell_mem[i_addr];
    end

    assign o_busy = r_clearing;
endmodule

FILE: src/brainfuck_instruction_step.sv
// Top level: sequencer, code store and pointers of the Brainfuck step engine.
// One input item runs one instruction or loads one code byte and gives one result.
// A load item or a step while halted passes through accept and cell read-back; a simple
// instruction passes through accept, decode, pointer advance and cell read-back; a taken
// bracket adds a step state and a check state for every code byte scanned: the step moves
// the code pointer in the shared unit and reads the code store through its register. After
// reset all CELL_COUNT data cells (65536 by default) are swept to zero, with o_stall held
// high; configuration writes are taken throughout. The result sits in an output register,
// so the next item is taken while a result still waits.
module brainfuck_instruction_step #(
    parameter int CELL_COUNT = bfis_pkg::CELL_COUNT_DEF,
    parameter int CODE_DEPTH = bfis_pkg::CODE_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic                          i_kind,
    input  logic [bfis_pkg::ADDR_W-1:0]   i_load_address,
    input  logic [bfis_pkg::BYTE_W-1:0]   i_load_byte,
    input  logic [bfis_pkg::BYTE_W-1:0]   i_in_byte,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [bfis_pkg::LEN_W-1:0]    i_cfg_data,
    output logic                          o_res_valid,
    input  logic                          i_res_stall,
    output logic                          o_out_valid,
    output logic [bfis_pkg::BYTE_W-1:0]   o_out_byte,
    output logic                          o_break_hit,
    output logic                          o_halted,
    output logic [bfis_pkg::CP_OUT_W-1:0] o_code_pointer_now,
    output logic [bfis_pkg::DP_OUT_W-1:0] o_data_pointer_now,
    output logic [bfis_pkg::BYTE_W-1:0]   o_cell_now
);
    import bfis_pkg::*;

    localparam int CPW = $clog2(CODE_DEPTH + 2);
    localparam int CAW = $clog2(CODE_DEPTH);
    localparam int DAW = $clog2(CELL_COUNT);
    localparam int AW  = max_int(max_int(CPW, DAW + 1), BYTE_W);

    t_state r_state, n_state;

    logic [CPW-1:0]    r_cp;
    logic [DAW-1:0]    r_dp;
    logic [LEN_W-1:0]  r_len;
    logic [CPW-1:0]    r_depth;
    logic              r_emit;
    logic              r_brk;
    logic [BYTE_W-1:0] r_in_byte;
    logic [BYTE_W-1:0] r_out_byte;
    logic [BYTE_W-1:0] r_code_q;

    logic                r_res_valid;
    logic                r_o_out_valid;
    logic [BYTE_W-1:0]   r_o_out_byte;
    logic                r_o_break_hit;
    logic                r_o_halted;
    logic [CP_OUT_W-1:0] r_o_cp;
    logic [DP_OUT_W-1:0] r_o_dp;
    logic [BYTE_W-1:0]   r_o_cell;

    logic [BYTE_W-1:0] code_mem [CODE_DEPTH];

    logic [31:0]       len_ext, act_ext, load_ext, cp_ext, dp_ext;
    logic [CPW-1:0]    act_len;
    logic              halted_now;
    logic              accept;
    logic              load_ok;
    logic              out_load;

    logic [AW-1:0]     alu_a, alu_cmp, alu_sum;
    logic              alu_dec, alu_ge, alu_zero;
    logic [CAW-1:0]    code_rd_addr;
    t_cell_req         cell_req;
    logic [BYTE_W-1:0] cell_q;
    logic              clr_busy;

    always_comb begin
        len_ext  = 32'(r_len);
        act_ext  = (len_ext > 32'(CODE_DEPTH)) ? 32'(CODE_DEPTH) : len_ext;
        act_len  = act_ext[CPW-1:0];
        load_ext = 32'(i_load_address);
        load_ok  = (load_ext < 32'(CODE_DEPTH));
        cp_ext   = 32'(r_cp);
        dp_ext   = 32'(r_dp);
    end

    assign halted_now  = (r_cp >= act_len);
    assign o_stall     = (r_state != S_IDLE) || clr_busy;
    assign accept      = i_valid && !o_stall;
    assign out_load    = (r_state == S_CELL) && (!r_res_valid || !i_res_stall);
    assign o_cfg_ready = 1'b1;

    bfis_alu #(.W(AW)) u_alu (
        .i_a      (alu_a),
        .i_dec    (alu_dec),
        .i_cmp    (alu_cmp),
        .o_sum    (alu_sum),
        .o_ge     (alu_ge),
        .o_a_zero (alu_zero)
    );

    bfis_cells #(.CELL_COUNT(CELL_COUNT), .DAW(DAW)) u_cells (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (cell_req),
        .i_addr  (r_dp),
        .o_q     (cell_q),
        .o_busy  (clr_busy)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = (i_kind == KIND_EXEC && !halted_now) ? S_DECODE : S_CELL;
                end
            end
            S_DECODE: begin
                if (r_code_q == OP_OPEN && cell_q == '0) begin
                    n_state = S_FSTEP;
                end else if (r_code_q == OP_CLOSE && cell_q != '0) begin
                    n_state = S_BSTEP;
                end else begin
                    n_state = S_ADVANCE;
                end
            end
            S_FSTEP:   n_state = alu_ge ? S_ADVANCE : S_FCHECK;
            S_FCHECK: begin
                n_state = (r_code_q == OP_CLOSE && r_depth == '0) ? S_ADVANCE : S_FSTEP;
            end
            S_BSTEP:   n_state = alu_zero ? S_CELL : S_BCHECK;
            S_BCHECK: begin
                n_state = (r_code_q == OP_OPEN && r_depth == '0) ? S_ADVANCE : S_BSTEP;
            end
            S_ADVANCE: n_state = S_CELL;
            S_CELL:    n_state = out_load ? S_IDLE : S_CELL;
            default:   n_state = S_IDLE;
        endcase
    end

    // sequencer outputs: shared unit operands, code read address, cell write
    always_comb begin
        alu_a        = '0;
        alu_dec      = 1'b0;
        alu_cmp      = '0;
        code_rd_addr = r_cp[CAW-1:0];
        cell_req     = '{we: 1'b0, wdata: '0};
        unique case (r_state)
            S_DECODE: begin
                unique case (r_code_q)
                    OP_LEFT: begin
                        alu_a   = AW'(r_dp);
                        alu_dec = 1'b1;
                    end
                    OP_RIGHT: begin
                        alu_a   = AW'(r_dp);
                        alu_cmp = AW'(CELL_COUNT);
                    end
                    OP_PLUS: begin
                        alu_a    = AW'(cell_q);
                        cell_req = '{we: 1'b1, wdata: alu_sum[BYTE_W-1:0]};
                    end
                    OP_MINUS: begin
                        alu_a    = AW'(cell_q);
                        alu_dec  = 1'b1;
                        cell_req = '{we: 1'b1, wdata: alu_sum[BYTE_W-1:0]};
                    end
                    OP_COMMA: cell_req = '{we: 1'b1, wdata: r_in_byte};
                    default: ;
                endcase
            end
            S_FSTEP: begin
                alu_a        = AW'(r_cp);
                alu_cmp      = AW'(act_len);
                code_rd_addr = alu_sum[CAW-1:0];
            end
            S_FCHECK: begin
                alu_a   = AW'(r_depth);
                alu_dec = (r_code_q == OP_CLOSE);
            end
            S_BSTEP: begin
                alu_a        = AW'(r_cp);
                alu_dec      = 1'b1;
                code_rd_addr = alu_sum[CAW-1:0];
            end
            S_BCHECK: begin
                alu_a   = AW'(r_depth);
                alu_dec = (r_code_q == OP_OPEN);
            end
            S_ADVANCE: alu_a = AW'(r_cp);
            S_IDLE, S_CELL: ;
            default: ;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cp        <= '0;
            r_dp        <= '0;
            r_len       <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                r_len <= i_cfg_data;
            end
            if (out_load) begin
                r_res_valid <= 1'b1;
            end else if (!i_res_stall) begin
                r_res_valid <= 1'b0;
            end
            unique case (r_state)
                S_DECODE: begin
                    if (r_code_q == OP_LEFT) begin
                        r_dp <= alu_zero ? DAW'(CELL_COUNT - 1) : alu_sum[DAW-1:0];
                    end else if (r_code_q == OP_RIGHT) begin
                        r_dp <= alu_ge ? '0 : alu_sum[DAW-1:0];
                    end
                end
                S_FSTEP:   r_cp <= alu_ge ? act_len : alu_sum[CPW-1:0];
                S_BSTEP: begin
                    if (!alu_zero) begin
                        r_cp <= alu_sum[CPW-1:0];
                    end
                end
                S_ADVANCE: r_cp <= alu_sum[CPW-1:0];
                S_IDLE, S_FCHECK, S_BCHECK, S_CELL: ;
                default: ;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_emit    <= 1'b0;
            r_brk     <= 1'b0;
            r_in_byte <= i_in_byte;
        end
        case (r_state)
            S_DECODE: begin
                r_depth <= '0;
                if (r_code_q == OP_DOT) begin
                    r_emit     <= 1'b1;
                    r_out_byte <= cell_q;
                end
                if (r_code_q == OP_HASH) begin
                    r_brk <= 1'b1;
                end
            end
            S_FCHECK: begin
                if (r_code_q == OP_OPEN || (r_code_q == OP_CLOSE && r_depth != '0)) begin
                    r_depth <= alu_sum[CPW-1:0];
                end
            end
            S_BCHECK: begin
                if (r_code_q == OP_CLOSE || (r_code_q == OP_OPEN && r_depth != '0)) begin
                    r_depth <= alu_sum[CPW-1:0];
                end
            end
            default: ;
        endcase
        if (out_load) begin
            r_o_out_valid <= r_emit;
            r_o_out_byte  <= r_emit ? r_out_byte : '0;
            r_o_break_hit <= r_brk;
            r_o_halted    <= halted_now;
            r_o_cp        <= cp_ext[CP_OUT_W-1:0];
            r_o_dp        <= dp_ext[DP_OUT_W-1:0];
            r_o_cell      <= cell_q;
        end
    end

    // code store: write on load transfer, registered read
    always_ff @(posedge i_clk) begin
        if (accept && i_kind == KIND_LOAD && load_ok) begin
            code_mem[load_ext[CAW-1:0]] <= i_load_byte;
        end
        r_code_q <= code_mem[code_rd_addr];
    end

    assign o_res_valid        = r_res_valid;
    assign o_out_valid        = r_o_out_valid;
    assign o_out_byte         = r_o_out_byte;
    assign o_break_hit        = r_o_break_hit;
    assign o_halted           = r_o_halted;
    assign o_code_pointer_now = r_o_cp;
    assign o_data_pointer_now = r_o_dp;
    assign o_cell_now         = r_o_cell;
endmodule

FILE: src/bfis_check.sv
// Port-level checks for the step engine, bound to the top level.
module bfis_check (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_valid,
    input logic                          o_stall,
    input logic                          i_kind,
    input logic [bfis_pkg::ADDR_W-1:0]   i_load_address,
    input logic [bfis_pkg::BYTE_W-1:0]   i_load_byte,
    input logic [bfis_pkg::BYTE_W-1:0]   i_in_byte,
    input logic                          i_cfg_valid,
    input logic                          o_cfg_ready,
    input logic [bfis_pkg::LEN_W-1:0]    i_cfg_data,
    input logic                          o_res_valid,
    input logic                          i_res_stall,
    input logic                          o_out_valid,
    input logic [bfis_pkg::BYTE_W-1:0]   o_out_byte,
    input logic                          o_break_hit,
    input logic                          o_halted,
    input logic [bfis_pkg::CP_OUT_W-1:0] o_code_pointer_now,
    input logic [bfis_pkg::DP_OUT_W-1:0] o_data_pointer_now,
    input logic [bfis_pkg::BYTE_W-1:0]   o_cell_now
);
    // a stalled result holds
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && i_res_stall) |=> (o_res_valid && $stable(o_code_pointer_now)
            && $stable(o_data_pointer_now) && $stable(o_cell_now)))
        else $error("result changed while stalled");

    // a transfer is always followed by a stall
    a_busy_after_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("input taken on consecutive cycles");

    // one instruction cannot both emit and break
    a_emit_break: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> !(o_out_valid && o_break_hit))
        else $error("emit and breakpoint in one result");

    // without an emit, the out byte reads as zero
    a_quiet_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && !o_out_valid) |-> (o_out_byte == '0))
        else $error("out byte set without emit");
endmodule

bind brainfuck_instruction_step bfis_check u_bfis_check (.*);

FILE: test/brainfuck_instruction_step_tb.sv
// Self-checking testbench for the Brainfuck instruction step engine.
module brainfuck_instruction_step_tb;
    import bfis_pkg::*;

    localparam int CODE_DEPTH   = CODE_DEPTH_DEF;
    localparam int CELL_COUNT   = CELL_COUNT_DEF;
    localparam int HOLD_CYCLES  = 400;
    localparam int SETTLE       = 8;
    localparam int REPORT_CAP   = 200;
    // Worst case: every execute a full-store scan plus the clear sweep, gaps and stalls
    // on some 5k transfers; taken several times over.
    localparam int LIMIT_CYCLES = 40_000_000;

    // Directed program: backward miss, pointer wrap, cell wrap, jumps, emit, break.
    localparam logic [8*24-1:0] DEMO_PROG = {
        OP_PLUS, OP_CLOSE, OP_LEFT, OP_LEFT, OP_RIGHT, OP_MINUS, OP_MINUS, OP_MINUS,
        OP_COMMA, OP_OPEN, OP_OPEN, OP_CLOSE, OP_CLOSE, OP_COMMA, OP_DOT, OP_PLUS,
        OP_HASH, 8'h00, 8'hFF, OP_COMMA, OP_OPEN, OP_MINUS, OP_CLOSE, OP_OPEN
    };

    typedef struct packed {
        logic                out_valid;
        logic [BYTE_W-1:0]   out_byte;
        logic                break_hit;
        logic                halted;
        logic [CP_OUT_W-1:0] code_ptr;
        logic [DP_OUT_W-1:0] data_ptr;
        logic [BYTE_W-1:0]   cell_value;
    } bf_result_t;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_valid = 1'b0;
    logic                  o_stall;
    logic                  i_kind = KIND_LOAD;
    logic [ADDR_W-1:0]     i_load_address = '0;
    logic [BYTE_W-1:0]     i_load_byte = '0;
    logic [BYTE_W-1:0]     i_in_byte = '0;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [LEN_W-1:0]      i_cfg_data = '0;
    logic                  o_res_valid;
    logic                  i_res_stall = 1'b0;
    logic                  o_out_valid;
    logic [BYTE_W-1:0]     o_out_byte;
    logic                  o_break_hit;
    logic                  o_halted;
    logic [CP_OUT_W-1:0]   o_code_pointer_now;
    logic [DP_OUT_W-1:0]   o_data_pointer_now;
    logic [BYTE_W-1:0]     o_cell_now;

    // Engine image kept by the testbench
    logic [BYTE_W-1:0] code_img [CODE_DEPTH];
    bit                code_seen [CODE_DEPTH];
    logic [BYTE_W-1:0] cell_img [CELL_COUNT];
    int                code_ptr_q = 0;
    int                data_ptr_q = 0;
    logic [LEN_W-1:0]  length_q = '0;

    bf_result_t results_due [$];
    int         mismatch_count = 0;
    int         cycle_count = 0;
    bit         tx_quiet = 1'b0;
    logic       rx_quiet = 1'b0;
    logic       hold_req = 1'b0;
    int         rx_hold_left = 0;
    int         rx_burst_left = 0;

    brainfuck_instruction_step i_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_kind             (i_kind),
        .i_load_address     (i_load_address),
        .i_load_byte        (i_load_byte),
        .i_in_byte          (i_in_byte),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_data         (i_cfg_data),
        .o_res_valid        (o_res_valid),
        .i_res_stall        (i_res_stall),
        .o_out_valid        (o_out_valid),
        .o_out_byte         (o_out_byte),
        .o_break_hit        (o_break_hit),
        .o_halted           (o_halted),
        .o_code_pointer_now (o_code_pointer_now),
        .o_data_pointer_now (o_data_pointer_now),
        .o_cell_now         (o_cell_now)
    );

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("brainfuck_instruction_step_tb NOT OK");
            $finish;
        end
    end

    // Carries out one item on the image and returns the result it must give.
    function automatic bf_result_t bf_execute(input logic kind, input logic [ADDR_W-1:0] addr,
                                              input logic [BYTE_W-1:0] lbyte,
                                              input logic [BYTE_W-1:0] ibyte);
        bf_result_t        r;
        int                lim;
        int                depth;
        logic [BYTE_W-1:0] op;
        logic [BYTE_W-1:0] cur;
        bit                advance;
        bit                scanning;
        bit                matched;
        r = '0;
        lim = (length_q > CODE_DEPTH) ? CODE_DEPTH : int'(length_q);
        if (kind == KIND_LOAD) begin
            code_img[addr] = lbyte;
        end else if (code_ptr_q < lim) begin
            op = code_img[code_ptr_q];
            cur = cell_img[data_ptr_q];
            advance = 1'b1;
            case (op)
                OP_LEFT:  data_ptr_q = (data_ptr_q == 0) ? CELL_COUNT - 1 : data_ptr_q - 1;
                OP_RIGHT: data_ptr_q = (data_ptr_q + 1 >= CELL_COUNT) ? 0 : data_ptr_q + 1;
                OP_PLUS:  cell_img[data_ptr_q] = cur + 8'd1;
                OP_MINUS: cell_img[data_ptr_q] = cur - 8'd1;
                OP_COMMA: cell_img[data_ptr_q] = ibyte;
                OP_DOT:   r.out_valid = 1'b1;
                OP_HASH:  r.break_hit = 1'b1;
                OP_OPEN: begin
                    if (cur == 8'd0) begin
                        depth = 0;
                        scanning = 1'b1;
                        while (scanning) begin
                            code_ptr_q++;
                            if (code_ptr_q >= lim) begin
                                code_ptr_q = lim;
                                scanning = 1'b0;
                            end else if (code_img[code_ptr_q] == OP_CLOSE) begin
                                if (depth == 0) scanning = 1'b0;
                                else depth--;
                            end else if (code_img[code_ptr_q] == OP_OPEN) begin
                                depth++;
                            end
                        end
                    end
                end
                OP_CLOSE: begin
                    if (cur != 8'd0) begin
                        depth = 0;
                        matched = 1'b0;
                        while (code_ptr_q > 0 && !matched) begin
                            code_ptr_q--;
                            if (code_img[code_ptr_q] == OP_OPEN) begin
                                if (depth == 0) matched = 1'b1;
                                else depth--;
                            end else if (code_img[code_ptr_q] == OP_CLOSE) begin
                                depth++;
                            end
                        end
                        // no match: parked at address 0 without the advance
                        if (!matched) advance = 1'b0;
                    end
                end
                default: ;
            endcase
            if (advance) code_ptr_q++;
            if (r.out_valid) r.out_byte = cell_img[data_ptr_q];
        end
        r.halted = (code_ptr_q >= lim);
        r.code_ptr = code_ptr_q[CP_OUT_W-1:0];
        r.data_ptr = data_ptr_q[DP_OUT_W-1:0];
        r.cell_value = cell_img[data_ptr_q];
        return r;
    endfunction

    function automatic int pick_idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [BYTE_W-1:0] filler_byte();
        logic [BYTE_W-1:0] b;
        b = $urandom_range(0, 255);
        if (b == OP_OPEN || b == OP_CLOSE) b = OP_PLUS;
        return b;
    endfunction

    function automatic logic [BYTE_W-1:0] plain_op();
        case ($urandom_range(0, 9))
            0, 1:    return OP_PLUS;
            2, 8:    return OP_MINUS;
            3:       return OP_LEFT;
            4:       return OP_RIGHT;
            5:       return OP_COMMA;
            6:       return OP_DOT;
            7:       return OP_HASH;
            default: return filler_byte();
        endcase
    endfunction

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] seen);
        if (want !== seen) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_CAP)
                $error("%s: expected %0d, got %0d", name, want, seen);
        end
    endtask

    // Result side: check every transfer, then choose the next stall.
    always @(posedge i_clk) begin
        bf_result_t want;
        if (i_rst_n && o_res_valid && !i_res_stall) begin
            if (results_due.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_CAP)
                    $error("result transfer with no step outstanding");
            end else begin
                want = results_due.pop_front();
                check_field("out_valid", want.out_valid, o_out_valid);
                check_field("out_byte", want.out_byte, o_out_byte);
                check_field("break_hit", want.break_hit, o_break_hit);
                check_field("halted", want.halted, o_halted);
                check_field("code_pointer_now", want.code_ptr, o_code_pointer_now);
                check_field("data_pointer_now", want.data_ptr, o_data_pointer_now);
                check_field("cell_now", want.cell_value, o_cell_now);
            end
        end
        if (rx_hold_left > 0) begin
            rx_hold_left--;
            i_res_stall <= 1'b1;
        end else if (hold_req) begin
            rx_hold_left = HOLD_CYCLES - 1;
            hold_req <= 1'b0;
            i_res_stall <= 1'b1;
        end else if (rx_burst_left > 0) begin
            rx_burst_left--;
            i_res_stall <= 1'b1;
        end else begin
            i_res_stall <= 1'b0;
            if (!rx_quiet && $urandom_range(0, 99) < 30) rx_burst_left = pick_idle_len();
        end
    end

    // Offers one item and waits for its transfer; valid stays high into the next item
    // unless a gap is drawn.
    task automatic send_item(input logic kind, input logic [ADDR_W-1:0] addr,
                             input logic [BYTE_W-1:0] lbyte, input logic [BYTE_W-1:0] ibyte);
        int gap;
        gap = tx_quiet ? 0 : pick_idle_len();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_kind         <= kind;
        i_load_address <= addr;
        i_load_byte    <= lbyte;
        i_in_byte      <= ibyte;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        results_due.push_back(bf_execute(kind, addr, lbyte, ibyte));
        if (kind == KIND_LOAD) code_seen[addr] = 1'b1;
    endtask

    task automatic load_code(input int addr, input logic [BYTE_W-1:0] b);
        send_item(KIND_LOAD, addr[ADDR_W-1:0], b, $urandom_range(0, 255));
    endtask

    task automatic exec_step(input logic [BYTE_W-1:0] ibyte);
        send_item(KIND_EXEC, $urandom_range(0, CODE_DEPTH - 1), $urandom_range(0, 255), ibyte);
    endtask

    // Every code byte below the length is written before any step may read it.
    task automatic load_missing(input int upto);
        for (int a = 0; a < upto; a++)
            if (!code_seen[a]) load_code(a, filler_byte());
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        while (results_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_length(input logic [LEN_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        length_q = value;
        @(posedge i_clk);
    endtask

    // Reset state: length 0 halts every step; loads report the idle state.
    task automatic test_reset_state();
        write_length('0);
        exec_step(8'hA5);
        load_code(0, OP_PLUS);
        exec_step(8'h5A);
    endtask

    task automatic test_directed_ops();
        for (int i = 0; i < 24; i++) load_code(i, DEMO_PROG[8*(23-i) +: 8]);
        drain_results();
        write_length(LEN_W'(24));
        exec_step($urandom_range(0, 255));  // + at 0
        exec_step($urandom_range(0, 255));  // ] with no opening bracket: back to 0
        load_code(1, OP_RIGHT);
        repeat (8) exec_step($urandom_range(0, 255));
        exec_step(8'h00);                   // , clears the cell
        exec_step($urandom_range(0, 255));  // [ skips the nested pair
        exec_step(8'hFF);
        repeat (5) exec_step($urandom_range(0, 255));
        exec_step(8'h02);
        repeat (6) exec_step($urandom_range(0, 255));  // loop taken once, then open miss
        repeat (2) exec_step($urandom_range(0, 255));  // halted
    endtask

    // Result side holds off while items keep coming, so the input stalls.
    task automatic test_backpressure();
        drain_results();
        tx_quiet = 1'b1;
        hold_req <= 1'b1;
        for (int i = 0; i < 40; i++) begin
            if ($urandom_range(0, 1) == 0) load_code($urandom_range(0, CODE_DEPTH - 1),
                                                     $urandom_range(0, 255));
            else exec_step($urandom_range(0, 255));
        end
        tx_quiet = 1'b0;
        drain_results();
    endtask

    task automatic test_random_programs();
        int                base;
        int                n;
        int                open;
        int                r;
        logic [BYTE_W-1:0] b;
        bit                broken;
        logic [LEN_W-1:0]  len;
        for (int p = 0; p < 12; p++) begin
            drain_results();
            base = code_ptr_q;
            n = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 120) : $urandom_range(4, 36);
            if (base + n > CODE_DEPTH - 8) n = CODE_DEPTH - 8 - base;
            broken = ($urandom_range(0, 3) == 0);
            tx_quiet = (p == 3);
            rx_quiet <= (p == 3);
            open = 0;
            for (int i = 0; i < n; i++) begin
                r = $urandom_range(0, 99);
                if (broken) begin
                    if (r < 15) b = OP_OPEN;
                    else if (r < 30) b = OP_CLOSE;
                    else if (r < 45) b = $urandom_range(0, 255);
                    else b = plain_op();
                end else if (open > 0 && n - i <= open) begin
                    b = OP_CLOSE;
                    open--;
                end else if (r < 12 && n - i > open + 1) begin
                    b = OP_OPEN;
                    open++;
                end else if (r < 22 && open > 0) begin
                    b = OP_CLOSE;
                    open--;
                end else begin
                    b = plain_op();
                end
                load_code(base + i, b);
            end
            load_missing(base + n);
            drain_results();
            // now and then a length at or below the code pointer: halted steps
            if (p % 6 == 5) len = $urandom_range(0, base);
            else len = base + n;
            write_length(len);
            for (int s = 0; s < 2 * n + 4; s++) begin
                if ($urandom_range(0, 9) == 0)
                    load_code($urandom_range(0, CODE_DEPTH - 1), $urandom_range(0, 255));
                else
                    exec_step($urandom_range(0, 255));
            end
        end
        tx_quiet = 1'b0;
        rx_quiet <= 1'b0;
    endtask

    // Full store, then a length above the depth: the open bracket scans to the end.
    task automatic test_length_extremes();
        int base;
        drain_results();
        load_missing(CODE_DEPTH);
        base = code_ptr_q;
        load_code(base, OP_COMMA);
        load_code(base + 1, OP_OPEN);
        load_code(CODE_DEPTH - 1, 8'hFF);
        drain_results();
        write_length({LEN_W{1'b1}});
        exec_step(8'h00);
        exec_step($urandom_range(0, 255));
        repeat (2) exec_step($urandom_range(0, 255));
        drain_results();
        write_length(LEN_W'(CODE_DEPTH));
        exec_step($urandom_range(0, 255));
        drain_results();
        write_length('0);
        exec_step($urandom_range(0, 255));
        load_code(0, 8'h00);
    endtask

    task automatic finish_run();
        drain_results();
        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0 && results_due.size() == 0) begin
            $display("brainfuck_instruction_step_tb OK");
        end else begin
            $display("brainfuck_instruction_step_tb NOT OK");
        end
        $finish;
    endtask

    initial begin
        for (int a = 0; a < CELL_COUNT; a++) cell_img[a] = 8'h00;
        for (int a = 0; a < CODE_DEPTH; a++) code_img[a] = 8'h00;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_state();
        test_directed_ops();
        test_backpressure();
        test_random_programs();
        test_length_extremes();
        finish_run();
    end

endmodule
